[src/assert_macros.svh]
// Assertion macros used by the clock-tree calculator queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge outside of reset.
`define PCF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When cond holds, expr must hold in the next cycle.
`define PCF_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   `PCF_ASSERT(label, clk, rst, (cond) |=> (expr), msg)

`endif

[src/pcf_pkg.sv]
// ----------------------------------------------------------------------------
// pcf_pkg
// Types, widths, constants and prescaler tables of the clock-tree calculator.
// ----------------------------------------------------------------------------
package pcf_pkg;

   localparam int unsigned HSE_W   = 26;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned VCO_W   = 35;
   localparam int unsigned CLK_W   = 34;
   localparam int unsigned M_W     = 6;
   localparam int unsigned N_W     = 9;
   localparam int unsigned Q_W     = 4;
   localparam int unsigned PDIV_W  = 4;
   localparam int unsigned PCODE_W = 2;
   localparam int unsigned SRC_W   = 2;
   localparam int unsigned AHB_W   = 4;
   localparam int unsigned APB_W   = 3;
   localparam int unsigned SHIFT_W = 4;
   localparam int unsigned DIV_BITS_PER_STEP = 4;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [HSE_W-1:0] HSE_RESET = 26'd8000000;
   localparam logic [CLK_W-1:0] HSI_HZ    = 34'd16000000;

   // Decoded fields of one pair of configuration words.
   typedef struct packed {
      logic [M_W-1:0]     m;
      logic [N_W-1:0]     n;
      logic [PCODE_W-1:0] pcode;
      logic [Q_W-1:0]     q;
      logic [SRC_W-1:0]   src;
      logic [AHB_W-1:0]   ahb;
      logic [APB_W-1:0]   apb1;
      logic [APB_W-1:0]   apb2;
   } item_type;

   typedef enum logic [SRC_W-1:0] {
      SRC_HSI = 2'd0,
      SRC_HSE = 2'd1,
      SRC_PLL = 2'd2,
      SRC_OFF = 2'd3
   } src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIVM_GO,
      ST_DIVM,
      ST_PQ_GO,
      ST_PQ,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic pop;
      logic start_m;
      logic start_pq;
      logic load_out;
   } back_ctrl_type;

   // All AHB divisors are powers of two, so the table holds shift amounts.
   function automatic logic [SHIFT_W-1:0] ahb_shift(input logic [AHB_W-1:0] code);
      logic [SHIFT_W-1:0] s;
      unique case (code)
         4'd8:    s = 4'd1;
         4'd9:    s = 4'd2;
         4'd10:   s = 4'd3;
         4'd11:   s = 4'd4;
         4'd12:   s = 4'd6;
         4'd13:   s = 4'd7;
         4'd14:   s = 4'd8;
         4'd15:   s = 4'd9;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   function automatic logic [SHIFT_W-1:0] apb_shift(input logic [APB_W-1:0] code);
      logic [SHIFT_W-1:0] s;
      unique case (code)
         3'd4:    s = 4'd1;
         3'd5:    s = 4'd2;
         3'd6:    s = 4'd3;
         3'd7:    s = 4'd4;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   // P code 0..3 selects a divider of 2, 4, 6 or 8.
   function automatic logic [PDIV_W-1:0] p_divisor(input logic [PCODE_W-1:0] code);
      return {1'b0, code, 1'b0} + 4'd2;
   endfunction

endpackage

[src/pcf_divider.sv]
// ----------------------------------------------------------------------------
// pcf_divider
// Iterative restoring divider that retires several quotient bits per cycle.
// ----------------------------------------------------------------------------
module pcf_divider #(
   parameter int unsigned DIVIDEND_W    = 35,
   parameter int unsigned DIVISOR_W     = 6,
   parameter int unsigned BITS_PER_STEP = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int unsigned STEPS = (DIVIDEND_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int unsigned PAD_W = STEPS * BITS_PER_STEP;
   localparam int unsigned CNT_W = $clog2(STEPS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PAD_W-1:0]     num_ff, num_in;
   logic [PAD_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;

   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W-1:0] rem_v;
   logic [PAD_W-1:0]     num_v;
   logic [PAD_W-1:0]     quo_v;

   // One step of long division: shift in the next dividend bits one at a time.
   always_comb begin
      rem_v = rem_ff;
      num_v = num_ff;
      quo_v = quo_ff;
      trial = '0;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         trial = {rem_v, num_v[PAD_W-1]};
         num_v = {num_v[PAD_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_v = DIVISOR_W'(trial - {1'b0, dsr_ff});
            quo_v = {quo_v[PAD_W-2:0], 1'b1};
         end else begin
            rem_v = trial[DIVISOR_W-1:0];
            quo_v = {quo_v[PAD_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS);
         num_in  = PAD_W'(dividend);
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         num_in = num_v;
         quo_in = quo_v;
         rem_in = rem_v;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[DIVIDEND_W-1:0];

endmodule

[src/pcf_queue.sv]
// ----------------------------------------------------------------------------
// pcf_queue
// Short FIFO of decoded items between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcf_queue #(
   parameter int unsigned DEPTH = pcf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pcf_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output pcf_pkg::item_type pop_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   pcf_pkg::item_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = entries_ff[rd_ptr_ff];

   `PCF_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count over depth")
   `PCF_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop && !full, count_ff == $past(count_ff) + 1'b1, "queue push lost")
   `PCF_ASSERT_NEXT(a_pop_shrinks, clock, reset, pop && !push && valid, count_ff == $past(count_ff) - 1'b1, "queue pop lost")

endmodule

[src/pcf_front.sv]
// ----------------------------------------------------------------------------
// pcf_front
// Accepts configuration word pairs, extracts their fields and queues them.
// ----------------------------------------------------------------------------
module pcf_front #(
   parameter int unsigned QUEUE_DEPTH = pcf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [pcf_pkg::WORD_W-1:0] pll_word,
   input  logic [pcf_pkg::WORD_W-1:0] clock_word,
   input  logic                       item_pop,
   output logic                       item_valid,
   output pcf_pkg::item_type          item
);

   pcf_pkg::item_type decoded;
   logic              full;

   // Field layout of the two words; all other bits are ignored.
   always_comb begin
      decoded.m     = pll_word[5:0];
      decoded.n     = pll_word[14:6];
      decoded.pcode = pll_word[17:16];
      decoded.q     = pll_word[27:24];
      decoded.src   = clock_word[3:2];
      decoded.ahb   = clock_word[7:4];
      decoded.apb1  = clock_word[12:10];
      decoded.apb2  = clock_word[15:13];
   end

   assign req_stall = full;

   pcf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_valid),
      .push_item(decoded),
      .full     (full),
      .pop      (item_pop),
      .valid    (item_valid),
      .pop_item (item)
   );

endmodule

[src/pcf_back.sv]
// ----------------------------------------------------------------------------
// pcf_back
// Computes the clock tree of one queued item and holds it in the result
// register.
// ----------------------------------------------------------------------------
module pcf_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [pcf_pkg::HSE_W-1:0] hse_freq_hz,
   input  logic                      item_valid,
   input  pcf_pkg::item_type         item,
   output logic                      item_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [pcf_pkg::VCO_W-1:0] vco_hz,
   output logic [pcf_pkg::CLK_W-1:0] pll_p_hz,
   output logic [pcf_pkg::VCO_W-1:0] pll_q_hz,
   output logic [pcf_pkg::CLK_W-1:0] sysclk_hz,
   output logic [pcf_pkg::CLK_W-1:0] hclk_hz,
   output logic [pcf_pkg::CLK_W-1:0] pclk1_hz,
   output logic [pcf_pkg::CLK_W-1:0] pclk2_hz,
   output logic                      divide_error
);

   localparam int unsigned VCO_W = pcf_pkg::VCO_W;
   localparam int unsigned CLK_W = pcf_pkg::CLK_W;

   pcf_pkg::back_state_type state_ff, state_in;
   pcf_pkg::back_ctrl_type  ctrl;
   pcf_pkg::item_type       it_ff;
   logic [VCO_W-1:0]        prod_ff;
   logic [VCO_W-1:0]        vco_ff;
   logic                    out_free;

   logic                    m_done;
   logic                    p_done;
   logic                    q_done;
   logic [VCO_W-1:0]        m_quo;
   logic [VCO_W-1:0]        p_quo;
   logic [VCO_W-1:0]        q_quo;

   logic [CLK_W-1:0]        pclk_v;
   logic [VCO_W-1:0]        qclk_v;
   logic [CLK_W-1:0]        sys_v;
   logic [CLK_W-1:0]        hclk_v;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VCO_W-1:0]        vco_out_ff;
   logic [CLK_W-1:0]        pclk_out_ff;
   logic [VCO_W-1:0]        qclk_out_ff;
   logic [CLK_W-1:0]        sys_out_ff;
   logic [CLK_W-1:0]        hclk_out_ff;
   logic [CLK_W-1:0]        pclk1_out_ff;
   logic [CLK_W-1:0]        pclk2_out_ff;
   logic                    err_out_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcf_pkg::ST_IDLE:    if (item_valid) state_in = pcf_pkg::ST_MUL;
         pcf_pkg::ST_MUL:     state_in = pcf_pkg::ST_DIVM_GO;
         pcf_pkg::ST_DIVM_GO: state_in = pcf_pkg::ST_DIVM;
         pcf_pkg::ST_DIVM:    if (m_done) state_in = pcf_pkg::ST_PQ_GO;
         pcf_pkg::ST_PQ_GO:   state_in = pcf_pkg::ST_PQ;
         pcf_pkg::ST_PQ:      if (p_done && q_done) state_in = pcf_pkg::ST_OUT;
         pcf_pkg::ST_OUT:     if (out_free) state_in = pcf_pkg::ST_IDLE;
         default:             state_in = pcf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl.pop      = (state_ff == pcf_pkg::ST_IDLE) && item_valid;
      ctrl.start_m  = (state_ff == pcf_pkg::ST_DIVM_GO);
      ctrl.start_pq = (state_ff == pcf_pkg::ST_PQ_GO);
      ctrl.load_out = (state_ff == pcf_pkg::ST_OUT) && out_free;
   end

   assign item_pop = ctrl.pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.pop) begin
         it_ff <= item;
      end
      if (state_ff == pcf_pkg::ST_MUL) begin
         prod_ff <= VCO_W'(hse_freq_hz) * VCO_W'(it_ff.n);
      end
      if ((state_ff == pcf_pkg::ST_DIVM) && m_done) begin
         vco_ff <= (it_ff.m == '0) ? '0 : m_quo;
      end
   end

   pcf_divider #(
      .DIVIDEND_W   (VCO_W),
      .DIVISOR_W    (pcf_pkg::M_W),
      .BITS_PER_STEP(pcf_pkg::DIV_BITS_PER_STEP)
   ) u_div_m (
      .clock   (clock),
      .reset   (reset),
      .start   (ctrl.start_m),
      .dividend(prod_ff),
      .divisor (it_ff.m),
      .done    (m_done),
      .quotient(m_quo)
   );

   pcf_divider #(
      .DIVIDEND_W   (VCO_W),
      .DIVISOR_W    (pcf_pkg::PDIV_W),
      .BITS_PER_STEP(pcf_pkg::DIV_BITS_PER_STEP)
   ) u_div_p (
      .clock   (clock),
      .reset   (reset),
      .start   (ctrl.start_pq),
      .dividend(vco_ff),
      .divisor (pcf_pkg::p_divisor(it_ff.pcode)),
      .done    (p_done),
      .quotient(p_quo)
   );

   pcf_divider #(
      .DIVIDEND_W   (VCO_W),
      .DIVISOR_W    (pcf_pkg::Q_W),
      .BITS_PER_STEP(pcf_pkg::DIV_BITS_PER_STEP)
   ) u_div_q (
      .clock   (clock),
      .reset   (reset),
      .start   (ctrl.start_pq),
      .dividend(vco_ff),
      .divisor (it_ff.q),
      .done    (q_done),
      .quotient(q_quo)
   );

   // Final selection and the power-of-two AHB prescaler.
   always_comb begin
      pclk_v = p_quo[CLK_W-1:0];
      qclk_v = (it_ff.q == '0) ? '0 : q_quo;
      unique case (pcf_pkg::src_type'(it_ff.src))
         pcf_pkg::SRC_HSI: sys_v = pcf_pkg::HSI_HZ;
         pcf_pkg::SRC_HSE: sys_v = CLK_W'(hse_freq_hz);
         pcf_pkg::SRC_PLL: sys_v = pclk_v;
         pcf_pkg::SRC_OFF: sys_v = '0;
         default:          sys_v = '0;
      endcase
      hclk_v = sys_v >> pcf_pkg::ahb_shift(it_ff.ahb);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         vco_out_ff   <= vco_ff;
         pclk_out_ff  <= pclk_v;
         qclk_out_ff  <= qclk_v;
         sys_out_ff   <= sys_v;
         hclk_out_ff  <= hclk_v;
         pclk1_out_ff <= hclk_v >> pcf_pkg::apb_shift(it_ff.apb1);
         pclk2_out_ff <= hclk_v >> pcf_pkg::apb_shift(it_ff.apb2);
         err_out_ff   <= (it_ff.m == '0) || (it_ff.q == '0);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign vco_hz       = vco_out_ff;
   assign pll_p_hz     = pclk_out_ff;
   assign pll_q_hz     = qclk_out_ff;
   assign sysclk_hz    = sys_out_ff;
   assign hclk_hz      = hclk_out_ff;
   assign pclk1_hz     = pclk1_out_ff;
   assign pclk2_hz     = pclk2_out_ff;
   assign divide_error = err_out_ff;

endmodule

[src/pll_clock_tree_frequency_calc_core.sv]
// ----------------------------------------------------------------------------
// pll_clock_tree_frequency_calc_core
// Works out PLL and bus clock frequencies from two configuration words.
// ----------------------------------------------------------------------------
// Usage: the request channel carries a PLL configuration word and a clock
// configuration word per transfer. The response channel returns the VCO, PLL P,
// PLL Q, system, AHB and both APB frequencies in hertz plus a divide error flag
// that is set when the M or Q field is zero. The csr port writes the external
// oscillator frequency; write it only while no transfer is in flight.
// Sequence: the back end takes one item at a time through the pop, the
// multiply, the 35-bit division by M and then the divisions by P and Q, which
// run side by side; each division has a start state and retires four quotient
// bits per cycle. The result load follows, and the back end takes the next
// item from the queue only once that result is loaded.
// The front queue takes new requests while the back end is busy, so req_stall
// rises only once the queue is full.
// Reset clears the queue, the sequencer and the response valid and sets the
// oscillator frequency to 8 MHz. While rsp_valid and rsp_stall are both high the
// result register holds its value; the back end finishes its item and waits.
// ----------------------------------------------------------------------------
module pll_clock_tree_frequency_calc_core #(
   parameter int unsigned QUEUE_DEPTH = pcf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [pcf_pkg::HSE_W-1:0]  csr_hse_freq_hz,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [pcf_pkg::WORD_W-1:0] req_pll_config_word,
   input  logic [pcf_pkg::WORD_W-1:0] req_clock_config_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [pcf_pkg::VCO_W-1:0]  rsp_vco_hz,
   output logic [pcf_pkg::CLK_W-1:0]  rsp_pll_p_hz,
   output logic [pcf_pkg::VCO_W-1:0]  rsp_pll_q_hz,
   output logic [pcf_pkg::CLK_W-1:0]  rsp_sysclk_hz,
   output logic [pcf_pkg::CLK_W-1:0]  rsp_hclk_hz,
   output logic [pcf_pkg::CLK_W-1:0]  rsp_pclk1_hz,
   output logic [pcf_pkg::CLK_W-1:0]  rsp_pclk2_hz,
   output logic                       rsp_divide_error
);

   // The oscillator frequency register; the back end reads it directly.
   logic [pcf_pkg::HSE_W-1:0] hse_ff;
   logic [pcf_pkg::HSE_W-1:0] hse_in;

   logic              item_valid;
   logic              item_pop;
   pcf_pkg::item_type item;

   assign hse_in = csr_wr_en ? csr_hse_freq_hz : hse_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hse_ff <= pcf_pkg::HSE_RESET;
      end else begin
         hse_ff <= hse_in;
      end
   end

   // The front end decodes and queues requests independently of the back end.
   pcf_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .pll_word  (req_pll_config_word),
      .clock_word(req_clock_config_word),
      .item_pop  (item_pop),
      .item_valid(item_valid),
      .item      (item)
   );

   // The back end runs the multiply and divide sequence and owns the result
   // register, so a stalled response never blocks the queue from filling.
   pcf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .hse_freq_hz (hse_ff),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .vco_hz      (rsp_vco_hz),
      .pll_p_hz    (rsp_pll_p_hz),
      .pll_q_hz    (rsp_pll_q_hz),
      .sysclk_hz   (rsp_sysclk_hz),
      .hclk_hz     (rsp_hclk_hz),
      .pclk1_hz    (rsp_pclk1_hz),
      .pclk2_hz    (rsp_pclk2_hz),
      .divide_error(rsp_divide_error)
   );

endmodule
